>>> rtl/pkcc_pkg.sv
// Package for the pair-keyed contact cache: request/response structs,
// command and status codes, default sizes. No dependencies.
package pkcc_pkg;

   // Command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_RSVD   = 2'd3;

   // Insert status codes
   localparam logic [1:0] ST_STORED = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_NONE   = 2'd3;

   // Sizes
   localparam int PKCC_ENTRIES_DEFAULT = 16;
   localparam int PKCC_COORDS          = 6;
   localparam logic [15:0] TOL_RESET   = 16'd6554;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [15:0]        body_first;
      logic [15:0]        body_second;
      logic signed [31:0] point_a_x;
      logic signed [31:0] point_a_y;
      logic signed [31:0] point_a_z;
      logic signed [31:0] point_b_x;
      logic signed [31:0] point_b_y;
      logic signed [31:0] point_b_z;
      logic [15:0]        info_handle;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        pair_found;
      logic [15:0] found_handle;
      logic [1:0]  insert_status;
   } rsp_type;

endpackage

>>> rtl/pkcc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pkcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/pkcc_coord_cmp.sv
// Shared coordinate compare unit: checks |fresh - stored| <= tolerance at
// 34 bits so nothing overflows. No dependencies.
module pkcc_coord_cmp (
   input  logic signed [31:0] fresh,
   input  logic signed [31:0] stored,
   input  logic [15:0]        tol,
   output logic               close
);

   logic signed [33:0] diff;
   logic signed [33:0] tol_pos;
   logic signed [33:0] tol_neg;

   // Wide difference, then a two-sided bound check
   always_comb begin
      diff    = 34'(fresh) - 34'(stored);
      tol_pos = $signed({18'd0, tol});
      tol_neg = -tol_pos;
      close   = (diff <= tol_pos) && (diff >= tol_neg);
   end

endmodule

>>> rtl/pair_keyed_contact_cache_unit.sv
// Top level of the pair-keyed contact cache: sequencer, valid bits, tables.
// Uses pkcc_pkg, pkcc_ram and pkcc_coord_cmp.
//
//  channel   | ports                        | transfer when
//  ----------+------------------------------+-------------------------
//  request   | start, busy, req_item        | start && !busy
//  response  | rsp_strobe, rsp_item         | every cycle rsp_strobe is high
//  csr write | csr_valid, csr_ready, csr_wdata | csr_valid && csr_ready
//
// Clear and the reserved command are answered straight from idle. Insert and
// lookup scan the key table one entry per cycle through its single read port,
// stopping early on a key match; a lookup that finds its pair then runs the
// six coordinates through one shared compare unit, a new insert writes the six
// coordinates through the point table's write port. The response strobe is
// registered and comes in the cycle after the item completes. Synchronous
// reset clears the valid bits and sets the tolerance to its default; the
// response side cannot stall, and csr_ready is always high.
module pair_keyed_contact_cache_unit #(
   parameter int CACHE_ENTRIES = pkcc_pkg::PKCC_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pkcc_pkg::req_type req_item,
   output logic             rsp_strobe,
   output pkcc_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata
);
   import pkcc_pkg::*;

   localparam int IDX_W    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int PT_DEPTH = PKCC_COORDS * CACHE_ENTRIES;
   localparam int PT_AW    = $clog2(PT_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
   localparam logic [2:0] LAST_COORD = 3'(PKCC_COORDS - 1);
   localparam logic [2:0] PT_DONE    = 3'(PKCC_COORDS);

   // Sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_PT   = 2'd2;
   localparam logic [1:0] S_WR   = 2'd3;

   logic [1:0]               state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     free_found_ff, free_found_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]         match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]         wr_idx_ff, wr_idx_in;
   logic [PT_AW-1:0]         base_ff, base_in;
   logic [2:0]               pt_j_ff, pt_j_in;
   logic                     ok_ff, ok_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_type                  rsp_ff, rsp_in;
   logic [15:0]              tol_ff, tol_in;

   logic [IDX_W-1:0] key_rd_addr;
   logic [31:0]      key_rd_data;
   logic             key_we;
   logic [PT_AW-1:0] pt_rd_addr;
   logic             pt_rd_en;
   logic [31:0]      pt_rd_data;
   logic [PT_AW-1:0] pt_wr_addr;
   logic             pt_we;
   logic [15:0]      tag_rd_data;
   logic             tag_rd_en;
   logic [2:0]       coord_idx;
   logic [31:0]      coord_sel;
   logic             coord_close;
   logic             key_match;
   logic             free_now;
   logic [IDX_W-1:0] free_idx_now;
   logic             ok_next;

   function automatic logic [PT_AW-1:0] times6(input logic [IDX_W-1:0] idx);
      times6 = PT_AW'({idx, 2'b00}) + PT_AW'({idx, 1'b0});
   endfunction

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;
   assign csr_ready  = 1'b1;

   // Tables
   pkcc_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_idx_ff),
      .wr_data ({req_ff.body_first, req_ff.body_second}),
      .rd_en   (1'b1),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   pkcc_ram #(.WIDTH(32), .DEPTH(PT_DEPTH)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_wr_addr),
      .wr_data (coord_sel),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   pkcc_ram #(.WIDTH(16), .DEPTH(CACHE_ENTRIES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_ff.info_handle),
      .rd_en   (tag_rd_en),
      .rd_addr (match_idx_ff),
      .rd_data (tag_rd_data)
   );

   // Shared coordinate compare
   pkcc_coord_cmp u_cmp (
      .fresh  (coord_sel),
      .stored (pt_rd_data),
      .tol    (tol_ff),
      .close  (coord_close)
   );

   // Table port control
   always_comb begin
      if (state_ff == S_IDLE || cmp_idx_ff == LAST_IDX) begin
         key_rd_addr = '0;
      end else begin
         key_rd_addr = cmp_idx_ff + IDX_W'(1);
      end
      key_we     = (state_ff == S_WR) && (pt_j_ff == 3'd0);
      pt_we      = (state_ff == S_WR);
      pt_wr_addr = base_ff + PT_AW'(pt_j_ff);
      pt_rd_en   = (state_ff == S_PT) && (pt_j_ff < PT_DONE);
      pt_rd_addr = base_ff + PT_AW'(pt_j_ff);
      tag_rd_en  = (state_ff == S_PT);
      coord_idx  = (state_ff == S_WR) ? pt_j_ff : pt_j_ff - 3'd1;
   end

   // Coordinate select from the held request
   always_comb begin
      unique case (coord_idx)
         3'd0:    coord_sel = req_ff.point_a_x;
         3'd1:    coord_sel = req_ff.point_a_y;
         3'd2:    coord_sel = req_ff.point_a_z;
         3'd3:    coord_sel = req_ff.point_b_x;
         3'd4:    coord_sel = req_ff.point_b_y;
         3'd5:    coord_sel = req_ff.point_b_z;
         default: coord_sel = '0;
      endcase
   end

   // Scan-stage decisions
   always_comb begin
      key_match    = valid_ff[cmp_idx_ff] &&
                     (key_rd_data == {req_ff.body_first, req_ff.body_second});
      free_now     = free_found_ff || !valid_ff[cmp_idx_ff];
      free_idx_now = free_found_ff ? free_idx_ff : cmp_idx_ff;
      ok_next      = ok_ff && coord_close;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      match_idx_in  = match_idx_ff;
      wr_idx_in     = wr_idx_ff;
      base_in       = base_ff;
      pt_j_in       = pt_j_ff;
      ok_in         = ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_item;
               cmp_idx_in    = '0;
               free_found_in = 1'b0;
               unique case (req_item.cmd)
                  CMD_CLEAR: begin
                     valid_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{1'b0, 1'b0, 16'd0, ST_NONE};
                  end
                  CMD_INSERT, CMD_LOOKUP: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{1'b0, 1'b0, 16'd0, ST_NONE};
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            if (!free_found_ff && !valid_ff[cmp_idx_ff]) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (key_match) begin
               if (req_ff.cmd == CMD_LOOKUP) begin
                  match_idx_in = cmp_idx_ff;
                  base_in      = times6(cmp_idx_ff);
                  pt_j_in      = 3'd0;
                  ok_in        = 1'b1;
                  state_in     = S_PT;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{1'b0, 1'b0, 16'd0, ST_DUP};
                  state_in      = S_IDLE;
               end
            end else if (cmp_idx_ff == LAST_IDX) begin
               if (req_ff.cmd == CMD_LOOKUP) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{1'b0, 1'b0, 16'd0, ST_NONE};
                  state_in      = S_IDLE;
               end else if (free_now) begin
                  wr_idx_in = free_idx_now;
                  base_in   = times6(free_idx_now);
                  pt_j_in   = 3'd0;
                  state_in  = S_WR;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{1'b0, 1'b0, 16'd0, ST_FULL};
                  state_in      = S_IDLE;
               end
            end
         end
         S_PT: begin
            // Read coordinate j, compare coordinate j-1
            pt_j_in = pt_j_ff + 3'd1;
            if (pt_j_ff != 3'd0) begin
               ok_in = ok_next;
            end
            if (pt_j_ff == PT_DONE) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{ok_next, 1'b1, ok_next ? tag_rd_data : 16'd0, ST_NONE};
               state_in      = S_IDLE;
            end
         end
         S_WR: begin
            pt_j_in = pt_j_ff + 3'd1;
            if (pt_j_ff == 3'd0) begin
               valid_in[wr_idx_ff] = 1'b1;
            end
            if (pt_j_ff == LAST_COORD) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{1'b0, 1'b0, 16'd0, ST_STORED};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Tolerance register
   always_comb begin
      tol_in = tol_ff;
      if (csr_valid && csr_ready) begin
         tol_in = csr_wdata;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         tol_ff        <= TOL_RESET;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         tol_ff        <= tol_in;
         free_found_ff <= free_found_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cmp_idx_ff   <= cmp_idx_in;
      free_idx_ff  <= free_idx_in;
      match_idx_ff <= match_idx_in;
      wr_idx_ff    <= wr_idx_in;
      base_ff      <= base_in;
      pt_j_ff      <= pt_j_in;
      ok_ff        <= ok_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   // A hit always comes from a lookup that found its pair
   a_hit_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.hit |-> rsp_item.pair_found && rsp_item.insert_status == ST_NONE)
      else $error("hit without pair_found");

   // Clear answers next cycle and empties the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.cmd == CMD_CLEAR |=> rsp_strobe && valid_ff == '0)
      else $error("clear did not complete");

   // An insert only fills a slot that was free
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR && pt_j_ff == 3'd0 |-> !valid_ff[wr_idx_ff])
      else $error("insert into occupied slot");

   // No response while an item is still in the scan or point phases
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_in) == S_IDLE)
      else $error("response before item finished");
`endif

endmodule
